>>> rtl/dev_pkg.sv
package dev_pkg;

  localparam int WORD_W = 32;

  typedef enum logic [2:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_READ       = 3'd4,
    MODE_WRITE      = 3'd5,
    MODE_INSERT     = 3'd6,
    MODE_REMOVE     = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // per-cell update select
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_FROM_PREV = 2'd2,
    CELL_FROM_NEXT = 2'd3
  } cell_op_t;

endpackage

>>> rtl/double_ended_vector_core.sv
// Results are registered: a result appears in the cycle after its request transfer.
// Throughput: 1 request per cycle unless out_ready stalls; each request moves
//   the row at most one place, so insert and remove too are one row update.
// Reset: rst_n (synchronous, active low) clears the element count and the
//   result valid; element cells are not cleared and are only read once written.
module double_ended_vector_core #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         in_mode,
  input  logic signed [dev_pkg::WORD_W-1:0]  in_value,
  input  logic [4:0]                         in_position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [dev_pkg::WORD_W-1:0]  out_read_data,
  output logic [1:0]                         out_status,
  output logic [4:0]                         out_fill_count
);
  import dev_pkg::*;

  // count needs to hold DEPTH itself; EW is a common compare width for the
  // count and the 5-bit position port.
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int EW = (CW > 5) ? CW : 5;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  logic                    out_valid_r;
  logic signed [WORD_W-1:0] rd_data_r;
  status_t                 status_r;
  logic [4:0]              fill_r;

  logic                    accept;
  mode_t                   mode;
  logic [EW-1:0]           pos_ext;
  logic [EW-1:0]           cnt_ext;
  logic                    full;
  logic                    empty;
  logic                    pos_ok;
  status_t                 status;
  logic                    do_update;
  logic                    do_read;
  logic [IW-1:0]           rd_sel;
  logic signed [WORD_W-1:0] rd_data;
  logic [EW-1:0]           fill_ext;

  logic signed [WORD_W-1:0] cell_q [DEPTH];

  // Output register splits the two sides: a new request is taken while the
  // held result is being handed off.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign mode    = mode_t'(in_mode);
  assign pos_ext = EW'(in_position);
  assign cnt_ext = EW'(count_r);
  assign full    = (cnt_ext >= EW'(DEPTH));
  assign empty   = (count_r == '0);
  assign pos_ok  = (pos_ext < cnt_ext);

  // Status, new count and which element (if any) is returned.
  always_comb begin
    status    = ST_OK;
    count_nxt = count_r;
    do_read   = 1'b0;
    rd_sel    = IW'(pos_ext);
    case (mode)
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (full) status = ST_FULL;
        else      count_nxt = CW'(count_r + 1'b1);
      end
      MODE_POP_BACK: begin
        rd_sel = IW'(cnt_ext - 1'b1);
        if (empty) status = ST_EMPTY;
        else begin
          count_nxt = CW'(count_r - 1'b1);
          do_read   = 1'b1;
        end
      end
      MODE_POP_FRONT: begin
        rd_sel = '0;
        if (empty) status = ST_EMPTY;
        else begin
          count_nxt = CW'(count_r - 1'b1);
          do_read   = 1'b1;
        end
      end
      MODE_READ: begin
        if (pos_ok) do_read = 1'b1;
        else        status  = ST_RANGE;
      end
      MODE_WRITE: begin
        if (!pos_ok) status = ST_RANGE;
      end
      MODE_INSERT: begin
        // full check wins over the index check; pos == count appends
        if (full)                   status = ST_FULL;
        else if (pos_ext > cnt_ext) status = ST_RANGE;
        else                        count_nxt = CW'(count_r + 1'b1);
      end
      MODE_REMOVE: begin
        if (pos_ok) begin
          count_nxt = CW'(count_r - 1'b1);
          do_read   = 1'b1;
        end else begin
          status = ST_RANGE;
        end
      end
      default: status = ST_OK;
    endcase
  end

  assign do_update = accept && (status == ST_OK);

  // rd_sel is only in range when do_read is set
  assign rd_data  = do_read ? cell_q[rd_sel] : '0;
  assign fill_ext = EW'(count_nxt);

  // Cell row: slot 0 is the front. Each cell loads the request word, takes
  // its front-side neighbor (gap opens), its back-side neighbor (gap closes) or holds.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [EW-1:0] IDX = EW'(i);
    cell_op_t                 op;
    logic signed [WORD_W-1:0] prev_d;
    logic signed [WORD_W-1:0] next_d;

    if (i == 0) begin : g_first
      assign prev_d = cell_q[i];
    end else begin : g_prev
      assign prev_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_d = cell_q[i];
    end else begin : g_next
      assign next_d = cell_q[i+1];
    end

    always_comb begin
      op = CELL_HOLD;
      if (do_update) begin
        case (mode)
          MODE_PUSH_BACK: begin
            if (IDX == cnt_ext) op = CELL_LOAD;
          end
          MODE_PUSH_FRONT: begin
            if (IDX == '0) op = CELL_LOAD;
            else           op = CELL_FROM_PREV;
          end
          MODE_POP_FRONT: op = CELL_FROM_NEXT;
          MODE_WRITE: begin
            if (IDX == pos_ext) op = CELL_LOAD;
          end
          MODE_INSERT: begin
            if (IDX == pos_ext)     op = CELL_LOAD;
            else if (IDX > pos_ext) op = CELL_FROM_PREV;
          end
          MODE_REMOVE: begin
            if (IDX >= pos_ext) op = CELL_FROM_NEXT;
          end
          default: op = CELL_HOLD;
        endcase
      end
    end

    dev_cell u_cell (
      .clk       (clk),
      .op        (op),
      .load_data (in_value),
      .prev_data (prev_d),
      .next_data (next_d),
      .data_q    (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_update) count_r <= count_nxt;
      if (accept)         out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= rd_data;
      status_r  <= status;
      fill_r    <= fill_ext[4:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = rd_data_r;
  assign out_status     = status_r;
  assign out_fill_count = fill_r;

endmodule

>>> rtl/dev_cell.sv
module dev_cell (
  input  logic                                clk,
  input  dev_pkg::cell_op_t                   op,
  input  logic signed [dev_pkg::WORD_W-1:0]   load_data,
  input  logic signed [dev_pkg::WORD_W-1:0]   prev_data,
  input  logic signed [dev_pkg::WORD_W-1:0]   next_data,
  output logic signed [dev_pkg::WORD_W-1:0]   data_q
);
  import dev_pkg::*;

  logic signed [WORD_W-1:0] data_r;
  logic signed [WORD_W-1:0] data_nxt;

  always_comb begin
    case (op)
      CELL_LOAD:      data_nxt = load_data;
      CELL_FROM_PREV: data_nxt = prev_data;
      CELL_FROM_NEXT: data_nxt = next_data;
      default:        data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule
